### src/sgm_pkg.sv
`timescale 1ns / 1ps

package sgm_pkg;

  localparam int SMP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int VOL_W  = 16;
  localparam int ACC_W  = 40;
  localparam int OPA_W  = 31;
  localparam int OPB_W  = 17;
  localparam int PROD_W = 48;
  localparam int QUO_W  = 18;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 32;
  localparam int FRAC_W = 30;

  localparam logic [VOL_W-1:0] VOL_UNITY = 16'd32768;

  localparam logic signed [ACC_W-1:0]  CLAMP_Q15 = 40'sd1073709056;
  localparam logic signed [ACC_W:0]    SUM_MAX   = 41'sd549755813887;
  localparam logic signed [ACC_W:0]    SUM_MIN   = -41'sd549755813888;
  localparam logic signed [QUO_W-1:0]  OUT_MAX   = 18'sd32767;
  localparam logic signed [PROD_W-1:0] ROUND_NEG = 48'sd1073741823;

  // Clamp a channel sum to +/-32767.0 in Q15 sample units.
  function automatic logic signed [OPA_W-1:0] clamp_sum(input logic signed [ACC_W-1:0] s);
    logic signed [OPA_W-1:0] r;
    if (s > CLAMP_Q15) begin
      r = OPA_W'(CLAMP_Q15);
    end else if (s < -CLAMP_Q15) begin
      r = OPA_W'(-CLAMP_Q15);
    end else begin
      r = s[OPA_W-1:0];
    end
    return r;
  endfunction

  // Add a product to an accumulator, saturating at the 40-bit limits.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    logic signed [ACC_W-1:0] r;
    t = (PROD_W+1)'(acc) + (PROD_W+1)'(p);
    if (t > (PROD_W+1)'(SUM_MAX)) begin
      r = SUM_MAX[ACC_W-1:0];
    end else if (t < (PROD_W+1)'(SUM_MIN)) begin
      r = SUM_MIN[ACC_W-1:0];
    end else begin
      r = t[ACC_W-1:0];
    end
    return r;
  endfunction

  // Divide by 2^30 toward zero, then saturate to +/-32767.
  function automatic logic signed [SMP_W-1:0] scale_out(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    logic signed [QUO_W-1:0]  q;
    logic signed [SMP_W-1:0]  r;
    b = (p < 0) ? (p + ROUND_NEG) : p;
    q = QUO_W'(b >>> FRAC_W);
    if (q > OUT_MAX) begin
      r = SMP_W'(OUT_MAX);
    end else if (q < -OUT_MAX) begin
      r = SMP_W'(-OUT_MAX);
    end else begin
      r = q[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/stereo_gain_mixer_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   tdata: samples, gains; tuser: playing; tlast: frame end
// m_*       out  m_tvalid / m_tready   tdata: left_out, right_out
// cfg_*     in   cfg_valid / cfg_ready cfg_data: output gain
//
// A source beat is accepted in S_IDLE, then passes through the one shared 31x17
// multiplier: left product, right product, last accumulate.
// A beat with tlast then adds two master-volume products on the same multiplier,
// the scaling of both results and the push into the output register.
// The push waits while a previous result still sits unaccepted on m_*.
// Reset clears both sums, drops m_tvalid and sets the output gain to unity.
module stereo_gain_mixer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [15:0] left_sample, [31:16] right_sample, [47:32] left_gain, [63:48] right_gain
  input  logic [sgm_pkg::IN_W-1:0]   s_tdata,
  // [0] contributes
  input  logic                       s_tuser,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [15:0] left_out, [31:16] right_out
  output logic [sgm_pkg::OUT_W-1:0]  m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sgm_pkg::VOL_W-1:0]  cfg_data
);

  import sgm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_L,
    S_MUL_R,
    S_ACC_R,
    S_FIN_L,
    S_FIN_R,
    S_DONE,
    S_PUSH
  } state_t;

  state_t state;

  logic [VOL_W-1:0]         out_gain;
  logic signed [ACC_W-1:0]  left_sum;
  logic signed [ACC_W-1:0]  right_sum;

  // Captured beat.
  logic signed [SMP_W-1:0]  l_smp;
  logic signed [SMP_W-1:0]  r_smp;
  logic [GAIN_W-1:0]        l_gain;
  logic [GAIN_W-1:0]        r_gain;
  logic                     playing;
  logic                     frame_end;

  // Shared multiplier, operands picked by the sequencer, product registered.
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod;

  logic signed [SMP_W-1:0]  left_res;
  logic signed [SMP_W-1:0]  right_res;

  logic out_free;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    unique case (state)
      S_MUL_L: begin
        op_a = OPA_W'(l_smp);
        op_b = $signed({1'b0, l_gain});
      end
      S_MUL_R: begin
        op_a = OPA_W'(r_smp);
        op_b = $signed({1'b0, r_gain});
      end
      S_FIN_L: begin
        op_a = clamp_sum(left_sum);
        op_b = $signed({1'b0, out_gain});
      end
      S_FIN_R: begin
        op_a = clamp_sum(right_sum);
        op_b = $signed({1'b0, out_gain});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_p = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      left_sum  <= '0;
      right_sum <= '0;
      out_gain  <= VOL_UNITY;
    end else begin
      if (cfg_valid && cfg_ready) begin
        out_gain <= cfg_data;
      end
      // Raise on a push, drop once the held beat is taken.
      if (state == S_PUSH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      prod <= mul_p;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            l_smp     <= $signed(s_tdata[15:0]);
            r_smp     <= $signed(s_tdata[31:16]);
            l_gain    <= s_tdata[47:32];
            r_gain    <= s_tdata[63:48];
            playing   <= s_tuser;
            frame_end <= s_tlast;
            state     <= S_MUL_L;
          end
        end
        S_MUL_L: state <= S_MUL_R;
        S_MUL_R: begin
          if (playing) begin
            left_sum <= sat_add(left_sum, prod);
          end
          state <= S_ACC_R;
        end
        S_ACC_R: begin
          if (playing) begin
            right_sum <= sat_add(right_sum, prod);
          end
          state <= frame_end ? S_FIN_L : S_IDLE;
        end
        S_FIN_L: state <= S_FIN_R;
        S_FIN_R: begin
          left_res <= scale_out(prod);
          state    <= S_DONE;
        end
        S_DONE: begin
          // Both master products are taken; clear the sums for the next frame.
          right_res <= scale_out(prod);
          left_sum  <= '0;
          right_sum <= '0;
          state     <= S_PUSH;
        end
        S_PUSH: begin
          // Hold until the output register is free.
          if (out_free) begin
            m_tdata <= {right_res, left_res};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_MUL_L))
    else $error("accepted beat did not start the multiply sequence");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (left_sum == '0 && right_sum == '0))
    else $error("sums not cleared at frame end");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_PUSH))
    else $error("result raised outside the push step");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000))
    else $error("output sample outside +/-32767");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> (out_gain == $past(cfg_data)))
    else $error("output gain write lost");

endmodule
